// ----- src/prbm_pkg.sv -----
// Shared types, constants and a helper function for the page residency budget manager.
`timescale 1ns / 1ps

package prbm_pkg;

	localparam int MAX_PAGES = 1024;
	localparam int PAGE_W    = 10;
	localparam int CNT_W     = 11;
	localparam int SIZE_W    = 24;
	localparam int BYTES_W   = 48;
	localparam int STAT_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 48;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM = 2'd2;

	// Item actions
	localparam logic [2:0] ACT_LOAD   = 3'd0;
	localparam logic [2:0] ACT_REQ    = 3'd1;
	localparam logic [2:0] ACT_UPLOAD = 3'd2;
	localparam logic [2:0] ACT_PROC   = 3'd3;
	localparam logic [2:0] ACT_FRAME  = 3'd4;
	localparam logic [2:0] ACT_QUERY  = 3'd5;

	// Result status codes
	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_RESIDENT = 3'd2;
	localparam logic [2:0] ST_BUDGET   = 3'd3;
	localparam logic [2:0] ST_NOREQ    = 3'd4;

	// Datapath operations issued by the controller
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_CLR     = 4'd1;
	localparam logic [3:0] OP_TAKE    = 4'd2;
	localparam logic [3:0] OP_CFG     = 4'd3;
	localparam logic [3:0] OP_DEC     = 4'd4;
	localparam logic [3:0] OP_UP_OK   = 4'd5;
	localparam logic [3:0] OP_EV_FAIL = 4'd6;
	localparam logic [3:0] OP_EVICT   = 4'd7;
	localparam logic [3:0] OP_EV_SKIP = 4'd8;
	localparam logic [3:0] OP_PP_DEC  = 4'd9;
	localparam logic [3:0] OP_PP_NEXT = 4'd10;
	localparam logic [3:0] OP_RC_ACC  = 4'd11;
	localparam logic [3:0] OP_OUT     = 4'd12;

	// Read address selects for the page stores
	localparam logic [1:0] RD_ITEM = 2'd0;
	localparam logic [1:0] RD_IDX  = 2'd1;
	localparam logic [1:0] RD_PTR  = 2'd2;

	typedef struct packed {
		logic [2:0]          action;
		logic [PAGE_W-1:0]   page_index;
		logic [STAT_W-1:0]   miss_count;
		logic                from_gpu;
		logic [SIZE_W-1:0]   byte_size;
	} in_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                page_resident;
		logic [PAGE_W-1:0]   fallback_page;
		logic [BYTES_W-1:0]  resident_bytes;
		logic [CNT_W-1:0]    resident_pages;
		logic [STAT_W-1:0]   miss_total;
		logic [STAT_W-1:0]   frame_misses;
		logic [STAT_W-1:0]   eviction_total;
	} out_t;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] rd_sel;
		logic       in_ready;
		logic       cfg_ready;
	} cmd_t;

	typedef struct packed {
		logic [2:0] act;
		logic       in_range;
		logic       res_bit;
		logic       cand;
		logic       over;
		logic       ptr_zero;
		logic       ev_hit;
		logic       idx_last;
		logic       rc_last;
		logic       out_free;
		logic       in_valid;
		logic       cfg_valid;
		logic       cfg_pages;
	} stat_t;

	// Saturating 32-bit add.
	function automatic logic [STAT_W-1:0] sat_add(input logic [STAT_W-1:0] a,
		input logic [STAT_W-1:0] b);
		logic [STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
	endfunction

endpackage

// ----- src/prbm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module prbm_ram #(
	parameter int W = 1,
	parameter int D = 2,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/prbm_dp.sv -----
// Datapath: page stores, residency sums, statistics counters, scan pointers and result register.
`timescale 1ns / 1ps

module prbm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  prbm_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output prbm_pkg::out_t                     out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [prbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prbm_pkg::CFG_DAT_W-1:0]     cfg_data,
	input  prbm_pkg::cmd_t                     cmd,
	output prbm_pkg::stat_t                    st
);

	prbm_pkg::in_t                      item_q;
	logic [prbm_pkg::BYTES_W-1:0]       budget_q;
	logic [prbm_pkg::CNT_W-1:0]         pcount_q;
	logic                               stream_q;
	logic [prbm_pkg::BYTES_W-1:0]       byte_sum_q;
	logic [prbm_pkg::CNT_W-1:0]         page_sum_q;
	logic [prbm_pkg::STAT_W-1:0]        miss_q;
	logic [prbm_pkg::STAT_W-1:0]        fmiss_q;
	logic [prbm_pkg::STAT_W-1:0]        evict_q;
	logic [prbm_pkg::PAGE_W-1:0]        idx_q;
	logic [prbm_pkg::PAGE_W-1:0]        ptr_q;
	logic [prbm_pkg::PAGE_W-1:0]        tgt_q;
	logic [prbm_pkg::SIZE_W-1:0]        need_q;
	logic [2:0]                         status_q;
	logic                               out_valid_q;
	prbm_pkg::out_t                     out_q;

	logic [prbm_pkg::PAGE_W-1:0]        raddr;
	logic                               res_rd;
	logic                               pend_rd;
	logic [prbm_pkg::SIZE_W-1:0]        size_rd;
	logic                               res_we;
	logic [prbm_pkg::PAGE_W-1:0]        res_wa;
	logic                               res_wd;
	logic                               pend_we;
	logic [prbm_pkg::PAGE_W-1:0]        pend_wa;
	logic                               pend_wd;
	logic                               size_we;
	logic [prbm_pkg::PAGE_W-1:0]        size_wa;
	logic [prbm_pkg::SIZE_W-1:0]        size_wd;

	logic                               in_range;
	logic [prbm_pkg::CNT_W-1:0]         pc_m1;
	logic [prbm_pkg::BYTES_W:0]         sum_need;
	logic                               over;
	logic [prbm_pkg::STAT_W-1:0]        req_m;
	logic                               req_ok;
	logic [2:0]                         dec_status;
	logic                               cand;
	logic [prbm_pkg::CNT_W-1:0]         clamp_pc;
	logic                               res_now;

	assign in_stall  = !cmd.in_ready;
	assign cfg_ready = cmd.cfg_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		case (cmd.rd_sel)
			prbm_pkg::RD_ITEM: raddr = item_q.page_index;
			prbm_pkg::RD_IDX:  raddr = idx_q;
			prbm_pkg::RD_PTR:  raddr = ptr_q;
			default:           raddr = idx_q;
		endcase
	end

	assign in_range = {1'b0, item_q.page_index} < pcount_q;
	assign pc_m1    = pcount_q - 11'd1;
	assign sum_need = {1'b0, byte_sum_q} + {{(prbm_pkg::BYTES_W + 1 - prbm_pkg::SIZE_W){1'b0}},
		need_q};
	assign over     = (budget_q != '0) && (sum_need > {1'b0, budget_q});
	assign req_m    = item_q.from_gpu ? item_q.miss_count : 32'd1;
	assign req_ok   = in_range && !(item_q.from_gpu && !stream_q) && !res_rd &&
		!(item_q.from_gpu && item_q.miss_count == '0);
	assign cand     = ({1'b0, idx_q} < pcount_q) && pend_rd && !res_rd;
	assign res_now  = in_range && res_rd;

	always_comb begin
		clamp_pc = cfg_data[prbm_pkg::CNT_W-1:0];
		if (clamp_pc == '0) begin
			clamp_pc = 11'd1;
		end else if (clamp_pc > 11'(prbm_pkg::MAX_PAGES)) begin
			clamp_pc = 11'(prbm_pkg::MAX_PAGES);
		end
	end

	always_comb begin
		case (item_q.action)
			prbm_pkg::ACT_LOAD:  dec_status = in_range ? prbm_pkg::ST_DONE : prbm_pkg::ST_RANGE;
			prbm_pkg::ACT_REQ: begin
				if (!in_range || (item_q.from_gpu && !stream_q)) begin
					dec_status = prbm_pkg::ST_RANGE;
				end else if (res_rd) begin
					dec_status = prbm_pkg::ST_RESIDENT;
				end else if (item_q.from_gpu && item_q.miss_count == '0) begin
					dec_status = prbm_pkg::ST_NOREQ;
				end else begin
					dec_status = prbm_pkg::ST_DONE;
				end
			end
			prbm_pkg::ACT_UPLOAD: begin
				if (!in_range) begin
					dec_status = prbm_pkg::ST_RANGE;
				end else if (res_rd) begin
					dec_status = prbm_pkg::ST_RESIDENT;
				end else begin
					dec_status = prbm_pkg::ST_DONE;
				end
			end
			prbm_pkg::ACT_PROC:  dec_status = prbm_pkg::ST_DONE;
			prbm_pkg::ACT_FRAME: dec_status = prbm_pkg::ST_DONE;
			prbm_pkg::ACT_QUERY: dec_status = in_range ? prbm_pkg::ST_DONE : prbm_pkg::ST_RANGE;
			default:             dec_status = prbm_pkg::ST_RANGE;
		endcase
	end

	// Store write ports. The clearing pass after reset also zeroes the size
	// store, so a page that is resident but never sized counts zero bytes.
	always_comb begin
		res_we  = 1'b0;
		res_wa  = idx_q;
		res_wd  = 1'b0;
		pend_we = 1'b0;
		pend_wa = idx_q;
		pend_wd = 1'b0;
		size_we = 1'b0;
		size_wa = item_q.page_index;
		size_wd = item_q.byte_size;
		case (cmd.op)
			prbm_pkg::OP_CLR: begin
				res_we  = 1'b1;
				res_wd  = (idx_q == '0);
				pend_we = 1'b1;
				size_we = 1'b1;
				size_wa = idx_q;
				size_wd = '0;
			end
			prbm_pkg::OP_DEC: begin
				size_we = (item_q.action == prbm_pkg::ACT_LOAD) && in_range;
				pend_we = (item_q.action == prbm_pkg::ACT_REQ) && req_ok;
				pend_wa = item_q.page_index;
				pend_wd = 1'b1;
			end
			prbm_pkg::OP_UP_OK: begin
				res_we = 1'b1;
				res_wa = tgt_q;
				res_wd = 1'b1;
			end
			prbm_pkg::OP_EVICT: begin
				res_we = 1'b1;
				res_wa = ptr_q;
			end
			prbm_pkg::OP_PP_DEC: begin
				pend_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	prbm_ram #(.W(1), .D(prbm_pkg::MAX_PAGES)) u_res_ram (
		.clk  (clk),
		.we   (res_we),
		.waddr(res_wa),
		.wdata(res_wd),
		.raddr(raddr),
		.rdata(res_rd)
	);

	prbm_ram #(.W(1), .D(prbm_pkg::MAX_PAGES)) u_pend_ram (
		.clk  (clk),
		.we   (pend_we),
		.waddr(pend_wa),
		.wdata(pend_wd),
		.raddr(raddr),
		.rdata(pend_rd)
	);

	prbm_ram #(.W(prbm_pkg::SIZE_W), .D(prbm_pkg::MAX_PAGES)) u_size_ram (
		.clk  (clk),
		.we   (size_we),
		.waddr(size_wa),
		.wdata(size_wd),
		.raddr(raddr),
		.rdata(size_rd)
	);

	// Control and sum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= '0;
			pcount_q    <= 11'd1;
			stream_q    <= 1'b1;
			byte_sum_q  <= '0;
			page_sum_q  <= 11'd1;
			miss_q      <= '0;
			fmiss_q     <= '0;
			evict_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				prbm_pkg::OP_CLR: begin
					idx_q <= idx_q + 10'd1;
				end
				prbm_pkg::OP_CFG: begin
					case (cfg_index)
						prbm_pkg::CFG_BUDGET: budget_q <= cfg_data[prbm_pkg::BYTES_W-1:0];
						prbm_pkg::CFG_PAGES: begin
							pcount_q   <= clamp_pc;
							byte_sum_q <= '0;
							page_sum_q <= '0;
							idx_q      <= '0;
						end
						prbm_pkg::CFG_STREAM: stream_q <= cfg_data[0];
						default: begin
						end
					endcase
				end
				prbm_pkg::OP_DEC: begin
					case (item_q.action)
						prbm_pkg::ACT_LOAD: begin
							if (in_range && res_rd) begin
								byte_sum_q <= byte_sum_q - 48'(size_rd) + 48'(item_q.byte_size);
							end
						end
						prbm_pkg::ACT_REQ: begin
							if (req_ok) begin
								miss_q  <= prbm_pkg::sat_add(miss_q, req_m);
								fmiss_q <= prbm_pkg::sat_add(fmiss_q, req_m);
							end
						end
						prbm_pkg::ACT_PROC:  idx_q   <= '0;
						prbm_pkg::ACT_FRAME: fmiss_q <= '0;
						default: begin
						end
					endcase
				end
				prbm_pkg::OP_UP_OK: begin
					byte_sum_q <= sum_need[prbm_pkg::BYTES_W-1:0];
					page_sum_q <= page_sum_q + 11'd1;
				end
				prbm_pkg::OP_EVICT: begin
					byte_sum_q <= byte_sum_q - 48'(size_rd);
					page_sum_q <= page_sum_q - 11'd1;
					evict_q    <= prbm_pkg::sat_add(evict_q, 32'd1);
				end
				prbm_pkg::OP_PP_NEXT: begin
					idx_q <= idx_q + 10'd1;
				end
				prbm_pkg::OP_RC_ACC: begin
					if (res_rd) begin
						byte_sum_q <= byte_sum_q + 48'(size_rd);
						page_sum_q <= page_sum_q + 11'd1;
					end
					idx_q <= idx_q + 10'd1;
				end
				prbm_pkg::OP_OUT: begin
					out_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Item payload, upload target and result
	always_ff @(posedge clk) begin
		case (cmd.op)
			prbm_pkg::OP_TAKE: begin
				item_q <= in_data;
			end
			prbm_pkg::OP_DEC: begin
				status_q <= dec_status;
				tgt_q    <= item_q.page_index;
				need_q   <= size_rd;
				ptr_q    <= pc_m1[prbm_pkg::PAGE_W-1:0];
			end
			prbm_pkg::OP_PP_DEC: begin
				tgt_q  <= idx_q;
				need_q <= size_rd;
				ptr_q  <= pc_m1[prbm_pkg::PAGE_W-1:0];
			end
			prbm_pkg::OP_EV_FAIL: begin
				status_q <= prbm_pkg::ST_BUDGET;
			end
			prbm_pkg::OP_EVICT, prbm_pkg::OP_EV_SKIP: begin
				ptr_q <= ptr_q - 10'd1;
			end
			prbm_pkg::OP_OUT: begin
				out_q.status         <= status_q;
				out_q.page_resident  <= res_now;
				out_q.fallback_page  <= res_now ? item_q.page_index : '0;
				out_q.resident_bytes <= byte_sum_q;
				out_q.resident_pages <= page_sum_q;
				out_q.miss_total     <= miss_q;
				out_q.frame_misses   <= fmiss_q;
				out_q.eviction_total <= evict_q;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.act       = item_q.action;
		st.in_range  = in_range;
		st.res_bit   = res_rd;
		st.cand      = cand;
		st.over      = over;
		st.ptr_zero  = (ptr_q == '0);
		st.ev_hit    = (ptr_q != tgt_q) && res_rd;
		st.idx_last  = (idx_q == {prbm_pkg::PAGE_W{1'b1}});
		st.rc_last   = ({1'b0, idx_q} == pc_m1);
		st.out_free  = !out_valid_q || !out_stall;
		st.in_valid  = in_valid;
		st.cfg_valid = cfg_valid;
		st.cfg_pages = (cfg_index == prbm_pkg::CFG_PAGES);
	end

endmodule

// ----- src/prbm_ctrl.sv -----
// Controller state machine sequencing items, uploads, eviction scans and sweeps.
`timescale 1ns / 1ps

module prbm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  prbm_pkg::stat_t st,
	output prbm_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_RD      = 4'd2;
	localparam logic [3:0] S_DEC     = 4'd3;
	localparam logic [3:0] S_UP_CHK  = 4'd4;
	localparam logic [3:0] S_UP_OK   = 4'd5;
	localparam logic [3:0] S_EV_RD   = 4'd6;
	localparam logic [3:0] S_EV_DEC  = 4'd7;
	localparam logic [3:0] S_PP_RD   = 4'd8;
	localparam logic [3:0] S_PP_DEC  = 4'd9;
	localparam logic [3:0] S_PP_NEXT = 4'd10;
	localparam logic [3:0] S_FIN_RD  = 4'd11;
	localparam logic [3:0] S_FIN     = 4'd12;
	localparam logic [3:0] S_RC_RD   = 4'd13;
	localparam logic [3:0] S_RC_ACC  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic [3:0] ret_st;

	// After an upload, either continue the pending sweep or report.
	assign ret_st = (st.act == prbm_pkg::ACT_PROC) ? S_PP_NEXT : S_FIN_RD;

	always_comb begin
		state_nx      = state_q;
		cmd.op        = prbm_pkg::OP_NONE;
		cmd.rd_sel    = prbm_pkg::RD_ITEM;
		cmd.in_ready  = 1'b0;
		cmd.cfg_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.op = prbm_pkg::OP_CLR;
				if (st.idx_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.cfg_ready = 1'b1;
				cmd.in_ready  = !st.cfg_valid;
				if (st.cfg_valid) begin
					cmd.op = prbm_pkg::OP_CFG;
					if (st.cfg_pages) begin
						state_nx = S_RC_RD;
					end
				end else if (st.in_valid) begin
					cmd.op   = prbm_pkg::OP_TAKE;
					state_nx = S_RD;
				end
			end
			S_RD: begin
				state_nx = S_DEC;
			end
			S_DEC: begin
				cmd.op = prbm_pkg::OP_DEC;
				if (st.act == prbm_pkg::ACT_UPLOAD && st.in_range && !st.res_bit) begin
					state_nx = S_UP_CHK;
				end else if (st.act == prbm_pkg::ACT_PROC) begin
					state_nx = S_PP_RD;
				end else begin
					state_nx = S_FIN_RD;
				end
			end
			S_UP_CHK: begin
				state_nx = st.over ? S_EV_RD : S_UP_OK;
			end
			S_UP_OK: begin
				cmd.op   = prbm_pkg::OP_UP_OK;
				state_nx = ret_st;
			end
			S_EV_RD: begin
				cmd.rd_sel = prbm_pkg::RD_PTR;
				if (st.ptr_zero) begin
					cmd.op   = prbm_pkg::OP_EV_FAIL;
					state_nx = ret_st;
				end else begin
					state_nx = S_EV_DEC;
				end
			end
			S_EV_DEC: begin
				if (st.ev_hit) begin
					cmd.op   = prbm_pkg::OP_EVICT;
					state_nx = S_UP_CHK;
				end else begin
					cmd.op   = prbm_pkg::OP_EV_SKIP;
					state_nx = S_EV_RD;
				end
			end
			S_PP_RD: begin
				cmd.rd_sel = prbm_pkg::RD_IDX;
				state_nx   = S_PP_DEC;
			end
			S_PP_DEC: begin
				cmd.op   = prbm_pkg::OP_PP_DEC;
				state_nx = st.cand ? S_UP_CHK : S_PP_NEXT;
			end
			S_PP_NEXT: begin
				cmd.op   = prbm_pkg::OP_PP_NEXT;
				state_nx = st.idx_last ? S_FIN_RD : S_PP_RD;
			end
			S_FIN_RD: begin
				state_nx = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.op   = prbm_pkg::OP_OUT;
					state_nx = S_IDLE;
				end
			end
			S_RC_RD: begin
				cmd.rd_sel = prbm_pkg::RD_IDX;
				state_nx   = S_RC_ACC;
			end
			S_RC_ACC: begin
				cmd.op   = prbm_pkg::OP_RC_ACC;
				state_nx = st.rc_last ? S_IDLE : S_RC_RD;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ----- src/page_residency_budget_manager_top.sv -----
// Top level of the page residency budget manager: controller plus datapath.
`timescale 1ns / 1ps

//  Channel  Direction  Handshake           Beat contents
//  in       to block   in_valid/in_stall   action, page, miss count, GPU flag, byte size
//  out      from block out_valid/out_stall status, residency, fallback, sums, counters
//  cfg      to block   cfg_valid/cfg_ready register index and write data
//
// Items are handled one at a time. Load size, request, begin frame and query
// pass through read, decode and report steps, and the next beat can be
// taken in the cycle the result appears. An upload adds a budget check and
// a commit, with a read and a decide step per page examined by the downward
// eviction scan and a new budget check after each eviction; process pending
// walks all 1024 pages, each with a read, decide and advance step, plus its
// uploads. The single read port of the page stores gives each page a read step.
// After reset the block clears all 1024 entries of its residency, pending
// and size stores before it accepts an item. Writing page_count starts a
// recount, a read and an accumulate step per page in range, during which
// items are stalled. A result waiting on a stalled output holds the block until it is taken.

module page_residency_budget_manager_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  prbm_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output prbm_pkg::out_t                 out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [prbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [prbm_pkg::CFG_DAT_W-1:0] cfg_data
);

	prbm_pkg::cmd_t  cmd;
	prbm_pkg::stat_t st;

	// The controller decides the sequence of operations; the datapath
	// holds every store, sum and counter and reports flags back.
	prbm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cmd   (cmd)
	);

	prbm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the page residency budget manager top level.
`timescale 1ns / 1ps

module testbench;

	// Action codes the block does not define; they must be answered with the range status and change nothing.
	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam int ITEMS_PER_PHASE = 340;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	prbm_pkg::in_t                        in_data = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	prbm_pkg::out_t                       out_data;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [prbm_pkg::CFG_IDX_W-1:0]       cfg_index = prbm_pkg::CFG_BUDGET;
	logic [prbm_pkg::CFG_DAT_W-1:0]       cfg_data = '0;

	page_residency_budget_manager_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Mirror of the block's state, advanced as each item beat is accepted.
	bit                                mirror_resident [prbm_pkg::MAX_PAGES];
	bit                                mirror_pending [prbm_pkg::MAX_PAGES];
	logic [prbm_pkg::SIZE_W-1:0]       mirror_size [prbm_pkg::MAX_PAGES];
	logic [63:0]                       mirror_budget;
	int                                mirror_pages;
	bit                                mirror_stream;
	logic [63:0]                       mirror_bytes;
	int                                mirror_count;
	logic [prbm_pkg::STAT_W-1:0]       mirror_misses, mirror_frame, mirror_evicts;

	// Generator-side view of which sizes were loaded, so that no upload or
	// request ever reads a size that was never written.
	bit  size_known [prbm_pkg::MAX_PAGES];
	int  gen_pages;

	prbm_pkg::in_t  pending_items [$];
	prbm_pkg::out_t expected_results [$];
	int   fail_count = 0;
	int   burst_left = 0;
	int   gap_left = 0;
	int   stall_mode = 0;
	int   stall_timer = 0;

	function automatic logic [prbm_pkg::STAT_W-1:0] add_sat(logic [prbm_pkg::STAT_W-1:0] a,
		logic [prbm_pkg::STAT_W-1:0] b);
		logic [prbm_pkg::STAT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[prbm_pkg::STAT_W] ? {prbm_pkg::STAT_W{1'b1}} : s[prbm_pkg::STAT_W-1:0];
	endfunction

	function automatic void tally_residency();
		mirror_bytes = '0;
		mirror_count = 0;
		for (int i = 0; i < mirror_pages; i++) begin
			if (mirror_resident[i]) begin
				mirror_count++;
				mirror_bytes += 64'(mirror_size[i]);
			end
		end
	endfunction

	// Make room under the budget by dropping the highest resident page other
	// than page 0 and the target; returns 0 when nothing is left to drop.
	function automatic bit admit_page(int pg);
		logic [63:0] need;
		int i;
		need = 64'(mirror_size[pg]);
		if (mirror_budget != 0) begin
			while (mirror_bytes + need > mirror_budget) begin
				i = mirror_pages - 1;
				while (i >= 1 && !(i != pg && mirror_resident[i]))
					i--;
				if (i < 1)
					return 1'b0;
				mirror_resident[i] = 1'b0;
				mirror_evicts = add_sat(mirror_evicts, 32'd1);
				tally_residency();
			end
		end
		mirror_resident[pg] = 1'b1;
		tally_residency();
		return 1'b1;
	endfunction

	function automatic prbm_pkg::out_t predict_residency(prbm_pkg::in_t it);
		prbm_pkg::out_t r;
		int pg;
		bit inr;
		logic [2:0] st;
		logic [prbm_pkg::STAT_W-1:0] m;
		pg = int'(it.page_index);
		inr = pg < mirror_pages;
		st = prbm_pkg::ST_DONE;
		tally_residency();
		case (it.action)
			prbm_pkg::ACT_LOAD: begin
				if (!inr) st = prbm_pkg::ST_RANGE;
				else mirror_size[pg] = it.byte_size;
			end
			prbm_pkg::ACT_REQ: begin
				if (!inr || (it.from_gpu && !mirror_stream)) st = prbm_pkg::ST_RANGE;
				else if (mirror_resident[pg]) st = prbm_pkg::ST_RESIDENT;
				else if (it.from_gpu && it.miss_count == 0) st = prbm_pkg::ST_NOREQ;
				else begin
					m = it.from_gpu ? it.miss_count : 32'd1;
					mirror_pending[pg] = 1'b1;
					mirror_misses = add_sat(mirror_misses, m);
					mirror_frame = add_sat(mirror_frame, m);
				end
			end
			prbm_pkg::ACT_UPLOAD: begin
				if (!inr) st = prbm_pkg::ST_RANGE;
				else if (mirror_resident[pg]) st = prbm_pkg::ST_RESIDENT;
				else if (!admit_page(pg)) st = prbm_pkg::ST_BUDGET;
			end
			prbm_pkg::ACT_PROC: begin
				for (int i = 0; i < mirror_pages; i++)
					if (mirror_pending[i] && !mirror_resident[i])
						if (!admit_page(i)) st = prbm_pkg::ST_BUDGET;
				foreach (mirror_pending[i]) mirror_pending[i] = 1'b0;
			end
			prbm_pkg::ACT_FRAME: mirror_frame = '0;
			prbm_pkg::ACT_QUERY: if (!inr) st = prbm_pkg::ST_RANGE;
			default: st = prbm_pkg::ST_RANGE;
		endcase
		tally_residency();
		r.status = st;
		r.page_resident = inr && mirror_resident[pg];
		r.fallback_page = r.page_resident ? it.page_index : '0;
		r.resident_bytes = mirror_bytes[prbm_pkg::BYTES_W-1:0];
		r.resident_pages = mirror_count[prbm_pkg::CNT_W-1:0];
		r.miss_total = mirror_misses;
		r.frame_misses = mirror_frame;
		r.eviction_total = mirror_evicts;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Sender: bursts of beats with random gaps; a stalled beat is held as is.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results = {expected_results, predict_residency(in_data)};
			if (in_valid && in_stall) begin
				// Hold the beat until the block takes it.
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall pattern changes whenever a random timer runs out, among
	// no stalls at all, light or heavy random back-pressure and on-off stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report("unexpected result beat", 64'(out_data.status), 64'd0);
				end else begin
					prbm_pkg::out_t w;
					w = expected_results.pop_front();
					if (out_data.status !== w.status)
						report("status", 64'(out_data.status), 64'(w.status));
					if (out_data.page_resident !== w.page_resident)
						report("page_resident", 64'(out_data.page_resident),
							64'(w.page_resident));
					if (out_data.fallback_page !== w.fallback_page)
						report("fallback_page", 64'(out_data.fallback_page),
							64'(w.fallback_page));
					if (out_data.resident_bytes !== w.resident_bytes)
						report("resident_bytes", 64'(out_data.resident_bytes),
							64'(w.resident_bytes));
					if (out_data.resident_pages !== w.resident_pages)
						report("resident_pages", 64'(out_data.resident_pages),
							64'(w.resident_pages));
					if (out_data.miss_total !== w.miss_total)
						report("miss_total", 64'(out_data.miss_total), 64'(w.miss_total));
					if (out_data.frame_misses !== w.frame_misses)
						report("frame_misses", 64'(out_data.frame_misses),
							64'(w.frame_misses));
					if (out_data.eviction_total !== w.eviction_total)
						report("eviction_total", 64'(out_data.eviction_total),
							64'(w.eviction_total));
				end
			end
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_timer = $urandom_range(50, 300);
			end else begin
				stall_timer--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= stall_timer[3];
			endcase
		end
	end

	// Queue one item beat and track which page sizes the block now holds.
	task automatic add_item(logic [2:0] act, int pg, logic [prbm_pkg::STAT_W-1:0] misses,
		bit gpu, logic [prbm_pkg::SIZE_W-1:0] bytes);
		prbm_pkg::in_t it;
		it.action = act;
		it.page_index = pg[prbm_pkg::PAGE_W-1:0];
		it.miss_count = misses;
		it.from_gpu = gpu;
		it.byte_size = bytes;
		if (act == prbm_pkg::ACT_LOAD && pg < gen_pages)
			size_known[pg] = 1'b1;
		pending_items = {pending_items, it};
	endtask

	// Waits until every queued beat has been taken and answered, then lets
	// the block settle before any register write.
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [prbm_pkg::CFG_IDX_W-1:0] idx,
		logic [prbm_pkg::CFG_DAT_W-1:0] value);
		logic [63:0] v;
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			prbm_pkg::CFG_BUDGET: mirror_budget = 64'(value);
			prbm_pkg::CFG_PAGES: begin
				v = 64'(value[10:0]);
				if (v < 1) v = 64'd1;
				if (v > prbm_pkg::MAX_PAGES) v = 64'(prbm_pkg::MAX_PAGES);
				mirror_pages = int'(v);
				gen_pages = int'(v);
			end
			prbm_pkg::CFG_STREAM: mirror_stream = value[0];
			default: ;
		endcase
		tally_residency();
	endtask

	function automatic logic [prbm_pkg::SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return 24'($urandom_range(0, 4095));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [prbm_pkg::STAT_W-1:0] pick_misses();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			3: return $urandom;
			default: return $urandom_range(1, 64);
		endcase
	endfunction

	// Random traffic: mostly loads, requests, uploads and queries on pages in
	// range, with some out-of-range pages and undefined actions mixed in.
	task automatic random_phase(int count);
		int roll, pg;
		logic [2:0] act;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			if (roll < 20) act = prbm_pkg::ACT_LOAD;
			else if (roll < 45) act = prbm_pkg::ACT_REQ;
			else if (roll < 60) act = prbm_pkg::ACT_UPLOAD;
			else if (roll < 67) act = prbm_pkg::ACT_PROC;
			else if (roll < 72) act = prbm_pkg::ACT_FRAME;
			else if (roll < 97) act = prbm_pkg::ACT_QUERY;
			else act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
			if ($urandom_range(0, 9) == 0)
				pg = $urandom_range(0, prbm_pkg::MAX_PAGES - 1);
			else
				pg = $urandom_range(0, gen_pages - 1);
			if ((act == prbm_pkg::ACT_REQ || act == prbm_pkg::ACT_UPLOAD) && pg < gen_pages &&
				!size_known[pg])
				act = prbm_pkg::ACT_LOAD;
			add_item(act, pg, pick_misses(), 1'($urandom_range(0, 1)), pick_size());
		end
	endtask

	initial begin
		mirror_budget = '0;
		mirror_pages = 1;
		gen_pages = 1;
		mirror_stream = 1'b1;
		mirror_misses = '0;
		mirror_frame = '0;
		mirror_evicts = '0;
		foreach (mirror_resident[i]) begin
			mirror_resident[i] = (i == 0);
			mirror_pending[i] = 1'b0;
			mirror_size[i] = '0;
			size_known[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Page 0 is resident from reset, so its size goes in before anything
		// else reads the resident byte total.
		add_item(prbm_pkg::ACT_LOAD, 0, '1, 1'b1, 24'h00_1000);
		drain();
		write_reg(prbm_pkg::CFG_BUDGET, 48'd0);
		write_reg(prbm_pkg::CFG_PAGES, 48'd8);
		write_reg(prbm_pkg::CFG_STREAM, 48'd1);

		// Directed part: extremes of each field and every action.
		add_item(prbm_pkg::ACT_LOAD, 7, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_LOAD, 1, '0, 1'b0, '1);
		for (int p = 2; p < 7; p++)
			add_item(prbm_pkg::ACT_LOAD, p, $urandom, 1'b1, 24'($urandom));
		add_item(prbm_pkg::ACT_LOAD, 1023, '1, 1'b1, '1);
		add_item(prbm_pkg::ACT_QUERY, 1023, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_REQ, 1023, '1, 1'b1, '0);
		add_item(prbm_pkg::ACT_UPLOAD, 1023, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_REQ, 1, '1, 1'b0, '0);
		add_item(prbm_pkg::ACT_REQ, 2, '0, 1'b1, '0);
		add_item(prbm_pkg::ACT_REQ, 3, '1, 1'b1, '0);
		add_item(prbm_pkg::ACT_REQ, 4, '1, 1'b1, '0);
		add_item(prbm_pkg::ACT_REQ, 0, 32'd5, 1'b1, '0);
		add_item(prbm_pkg::ACT_UPLOAD, 0, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_UPLOAD, 7, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_PROC, 3, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_QUERY, 3, '0, 1'b0, '0);
		add_item(prbm_pkg::ACT_FRAME, 0, '0, 1'b0, '0);
		add_item(ACT_SPARE_A, 2, '1, 1'b1, '1);
		add_item(ACT_SPARE_B, 5, '0, 1'b0, '0);
		random_phase(ITEMS_PER_PHASE);
		drain();

		// A tight budget with GPU requests switched off.
		write_reg(prbm_pkg::CFG_BUDGET, 48'd40_000_000);
		write_reg(prbm_pkg::CFG_PAGES, 48'd16);
		write_reg(prbm_pkg::CFG_STREAM, 48'd0);
		random_phase(ITEMS_PER_PHASE);
		drain();

		// Largest budget, and a page count beyond the limit that gets clamped.
		write_reg(prbm_pkg::CFG_BUDGET, {prbm_pkg::CFG_DAT_W{1'b1}});
		write_reg(prbm_pkg::CFG_PAGES, 48'd2047);
		write_reg(prbm_pkg::CFG_STREAM, 48'd1);
		random_phase(ITEMS_PER_PHASE);
		drain();

		// Page count of zero clamps to one, leaving only page 0, which stays resident; the budget is one byte.
		write_reg(prbm_pkg::CFG_PAGES, 48'd0);
		write_reg(prbm_pkg::CFG_BUDGET, 48'd1);
		random_phase(ITEMS_PER_PHASE / 3);
		drain();

		write_reg(prbm_pkg::CFG_PAGES, 48'd32);
		write_reg(prbm_pkg::CFG_BUDGET, 48'd60_000_000);
		random_phase(ITEMS_PER_PHASE);
		drain();

		write_reg(prbm_pkg::CFG_PAGES, 48'd12);
		write_reg(prbm_pkg::CFG_BUDGET, 48'd0);
		write_reg(prbm_pkg::CFG_STREAM, 48'd0);
		random_phase(ITEMS_PER_PHASE / 2);
		drain();
		write_reg(prbm_pkg::CFG_STREAM, 48'd1);
		random_phase(ITEMS_PER_PHASE / 2);
		drain();

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#1_000_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
src/prbm_pkg.sv
src/prbm_ram.sv
src/prbm_dp.sv
src/prbm_ctrl.sv
src/page_residency_budget_manager_top.sv
sim/testbench.sv
